@@ sv/lutm_pkg.sv @@
// Shared constants and inter-stage types of the 3D color table mapper.
package lutm_pkg;

	localparam int LUT_DIM   = 33;
	localparam int LUT_DEPTH = LUT_DIM * LUT_DIM * LUT_DIM;
	localparam int ADDR_W    = $clog2(LUT_DEPTH);
	localparam int N_W       = $clog2(LUT_DIM + 1);
	localparam int NN_W      = $clog2(LUT_DIM * LUT_DIM + 1);
	localparam int IDX_W     = $clog2(LUT_DIM);
	localparam int POS_W     = 8 + N_W;
	localparam int SIZE_W    = 6;
	localparam int CORNERS   = 8;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// Rounding and normalization by 255^3 through three exact divides by 255.
	localparam logic [31:0] DEN      = 32'(255 * 255 * 255);
	localparam logic [31:0] HALF     = 32'((255 * 255 * 255 - 1) / 2);
	localparam logic [31:0] RECIP    = 32'h8080_8081;
	localparam int          RECIP_SH = 39;

	typedef logic [23:0]       entry_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic            op;
		logic [15:0]     entry_index;
		entry_t          entry;
		logic [2:0][7:0] pixel;
		logic            last;
	} item_t;

	typedef struct packed {
		logic                      valid;
		logic                      op;
		logic                      wr_en;
		addr_t                     wr_addr;
		entry_t                    wr_data;
		logic [CORNERS-1:0][ADDR_W-1:0] rd_addr;
		logic [2:0][7:0]           fr;
		logic                      last;
	} idx2mem_t;

	typedef struct packed {
		logic                      valid;
		logic [CORNERS-1:0][23:0]  corner;
		logic [2:0][7:0]           fr;
		logic                      last;
	} mem2blend_t;

	typedef struct packed {
		logic             valid;
		logic [2:0][31:0] acc;
		logic             last;
	} blend2norm_t;

endpackage

@@ sv/lutm_item_if.sv @@
// Input channel carrying table writes and pixels.
interface lutm_item_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] entry_index;
	logic [7:0]  entry_red;
	logic [7:0]  entry_green;
	logic [7:0]  entry_blue;
	logic [7:0]  pixel_red;
	logic [7:0]  pixel_green;
	logic [7:0]  pixel_blue;
	logic        last_pixel;

	modport source (output valid, operation, entry_index, entry_red, entry_green, entry_blue,
		pixel_red, pixel_green, pixel_blue, last_pixel, input ready);
	modport sink (input valid, operation, entry_index, entry_red, entry_green, entry_blue,
		pixel_red, pixel_green, pixel_blue, last_pixel, output ready);
endinterface

@@ sv/lutm_result_if.sv @@
// Output channel carrying mapped pixels.
interface lutm_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] mapped_red;
	logic [7:0] mapped_green;
	logic [7:0] mapped_blue;
	logic       last_out;

	modport source (output valid, mapped_red, mapped_green, mapped_blue, last_out, input ready);
	modport sink (input valid, mapped_red, mapped_green, mapped_blue, last_out, output ready);
endinterface

@@ sv/lutm_cfg_if.sv @@
// Configuration write channel for the table size register.
interface lutm_cfg_if;
	logic       valid;
	logic       ready;
	logic [5:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ sv/lutm_index.sv @@
// Position split and corner address generation, stages one to three.
module lutm_index (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       item_valid,
	input  lutm_pkg::item_t            item,
	input  logic [lutm_pkg::N_W-1:0]   n,
	input  logic [lutm_pkg::NN_W-1:0]  nn,
	output lutm_pkg::idx2mem_t         to_mem
);
	import lutm_pkg::*;

	logic [N_W-1:0] max_idx;

	logic                      v_s1, op_s1, last_s1;
	logic [15:0]               eidx_s1;
	entry_t                    edat_s1;
	logic [2:0][POS_W-1:0]     pos_s1;

	logic                      v_s2, op_s2, last_s2;
	logic [15:0]               eidx_s2;
	entry_t                    edat_s2;
	logic [2:0][IDX_W-1:0]     lo_s2, hi_s2;
	logic [2:0][7:0]           fr_s2;

	logic [2:0][IDX_W-1:0]     lo_c, hi_c;
	logic [2:0][7:0]           fr_c;
	logic [CORNERS-1:0][ADDR_W-1:0] addr_c;

	logic                      v_s3;
	idx2mem_t                  out_s3;

	assign max_idx = n - N_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage one: channel position times (N-1).
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= item.op;
			last_s1 <= item.last;
			eidx_s1 <= item.entry_index;
			edat_s1 <= item.entry;
			for (int a = 0; a < 3; a++)
				pos_s1[a] <= POS_W'(item.pixel[a]) * POS_W'(max_idx);
		end
	end

	// Stage two: exact divide by 255 for positions below 2^16.
	always_comb begin
		logic [POS_W:0]   sum;
		logic [POS_W-1:0] lo_full;
		for (int a = 0; a < 3; a++) begin
			sum     = {1'b0, pos_s1[a]} + (POS_W+1)'(pos_s1[a] >> 8) + (POS_W+1)'(1);
			lo_full = POS_W'(sum >> 8);
			lo_c[a] = IDX_W'(lo_full);
			fr_c[a] = 8'(pos_s1[a] - (lo_full << 8) + lo_full);
			hi_c[a] = lo_c[a] + ((N_W'(lo_c[a]) < max_idx) ? IDX_W'(1) : IDX_W'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2   <= op_s1;
			last_s2 <= last_s1;
			eidx_s2 <= eidx_s1;
			edat_s2 <= edat_s1;
			lo_s2   <= lo_c;
			hi_s2   <= hi_c;
			fr_s2   <= fr_c;
		end
	end

	// Stage three: flat addresses of the eight corners.
	always_comb begin
		logic [2:0][IDX_W-1:0] ci;
		for (int c = 0; c < CORNERS; c++) begin
			for (int a = 0; a < 3; a++)
				ci[a] = ((c >> a) & 1) != 0 ? hi_s2[a] : lo_s2[a];
			addr_c[c] = ADDR_W'(ci[0]) + ADDR_W'(n) * ADDR_W'(ci[1])
				+ ADDR_W'(nn) * ADDR_W'(ci[2]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s3.op      <= op_s2;
			out_s3.wr_en   <= v_s2 && (op_s2 == OP_WRITE) && (32'(eidx_s2) < LUT_DEPTH);
			out_s3.wr_addr <= ADDR_W'(eidx_s2);
			out_s3.wr_data <= edat_s2;
			out_s3.rd_addr <= addr_c;
			out_s3.fr      <= fr_s2;
			out_s3.last    <= last_s2;
		end
	end

	assign to_mem = '{
		valid:   v_s3,
		op:      out_s3.op,
		wr_en:   out_s3.wr_en,
		wr_addr: out_s3.wr_addr,
		wr_data: out_s3.wr_data,
		rd_addr: out_s3.rd_addr,
		fr:      out_s3.fr,
		last:    out_s3.last
	};

	// The upper red corner is the lower one or the next, and a clamped blue axis has no fraction.
	a_hi_step: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (hi_s2[0] == lo_s2[0] || hi_s2[0] == lo_s2[0] + IDX_W'(1)))
		else $error("upper red corner is not next to the lower one");
	a_clamp_frac: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && hi_s2[2] == lo_s2[2] |-> fr_s2[2] == 8'd0)
		else $error("clamped blue axis carries a nonzero fraction");

endmodule

@@ sv/lutm_mem.sv @@
// Eight copies of the color table, one read port per corner, stage four.
module lutm_mem (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  lutm_pkg::idx2mem_t     from_idx,
	output lutm_pkg::mem2blend_t   to_blend
);
	import lutm_pkg::*;

	wire [CORNERS-1:0][23:0] corner_w;
	logic                    v_s4, last_s4;
	logic [2:0][7:0]         fr_s4;

	// Every write goes to all copies, so each corner has a port of its own.
	for (genvar k = 0; k < CORNERS; k++) begin : g_copy
		entry_t mem [LUT_DEPTH];
		entry_t rd_s4;
		always_ff @(posedge clk) begin
			if (adv && from_idx.wr_en)
				mem[from_idx.wr_addr] <= from_idx.wr_data;
			if (adv)
				rd_s4 <= mem[from_idx.rd_addr[k]];
		end
		assign corner_w[k] = rd_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (adv)
			v_s4 <= from_idx.valid && (from_idx.op == OP_PIXEL);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fr_s4   <= from_idx.fr;
			last_s4 <= from_idx.last;
		end
	end

	assign to_blend = '{valid: v_s4, corner: corner_w, fr: fr_s4, last: last_s4};

endmodule

@@ sv/lutm_blend.sv @@
// Trilinear weights and weighted corner sums, stages five to eight.
module lutm_blend (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  lutm_pkg::mem2blend_t  from_mem,
	output lutm_pkg::blend2norm_t to_norm
);
	import lutm_pkg::*;

	logic                     v_s5, v_s6, v_s7, v_s8;
	logic                     last_s5, last_s6, last_s7, last_s8;
	logic [CORNERS-1:0][23:0] cor_s5, cor_s6;
	logic [3:0][15:0]         wrg_s5;
	logic [1:0][7:0]          fb_s5;
	logic [CORNERS-1:0][23:0] w_s6;
	logic [CORNERS-1:0][2:0][31:0] p_s7;
	logic [2:0][31:0]         acc_s8;

	function automatic logic [7:0] fac(input logic up, input logic [7:0] fr);
		return up ? fr : 8'd255 - fr;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s5 <= from_mem.valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] sum;
		if (adv) begin
			// Stage five: red times green weights.
			for (int q = 0; q < 4; q++)
				wrg_s5[q] <= 16'(fac(q[0], from_mem.fr[0])) * 16'(fac(q[1], from_mem.fr[1]));
			fb_s5[0] <= fac(1'b0, from_mem.fr[2]);
			fb_s5[1] <= fac(1'b1, from_mem.fr[2]);
			cor_s5   <= from_mem.corner;
			last_s5  <= from_mem.last;
			// Stage six: full corner weight over 255^3.
			for (int c = 0; c < CORNERS; c++)
				w_s6[c] <= 24'(wrg_s5[c % 4]) * 24'(fb_s5[c / 4]);
			cor_s6  <= cor_s5;
			last_s6 <= last_s5;
			// Stage seven: weight times each channel of the corner.
			for (int c = 0; c < CORNERS; c++)
				for (int ch = 0; ch < 3; ch++)
					p_s7[c][ch] <= 32'(w_s6[c]) * 32'(cor_s6[c][8*ch +: 8]);
			last_s7 <= last_s6;
			// Stage eight: sum of eight products plus the rounding half.
			for (int ch = 0; ch < 3; ch++) begin
				sum = HALF;
				for (int c = 0; c < CORNERS; c++)
					sum = sum + p_s7[c][ch];
				acc_s8[ch] <= sum;
			end
			last_s8 <= last_s7;
		end
	end

	assign to_norm = '{valid: v_s8, acc: acc_s8, last: last_s8};

endmodule

@@ sv/lutm_norm.sv @@
// Division by 255^3 in three reciprocal steps and saturation, stages nine to eleven.
module lutm_norm (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  lutm_pkg::blend2norm_t from_blend,
	output logic                  valid,
	output logic [2:0][7:0]       mapped,
	output logic                  last
);
	import lutm_pkg::*;

	logic             v_s9, v_s10, v_s11;
	logic             last_s9, last_s10, last_s11;
	logic [2:0][23:0] q1_s9;
	logic [2:0][15:0] q2_s10;
	logic [2:0][7:0]  map_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s9  <= from_blend.valid;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		logic [63:0] prod;
		logic [8:0]  q3;
		if (adv) begin
			for (int ch = 0; ch < 3; ch++) begin
				prod = 64'(from_blend.acc[ch]) * 64'(RECIP);
				q1_s9[ch] <= 24'(prod >> RECIP_SH);
			end
			last_s9 <= from_blend.last;
			for (int ch = 0; ch < 3; ch++) begin
				prod = 64'(q1_s9[ch]) * 64'(RECIP);
				q2_s10[ch] <= 16'(prod >> RECIP_SH);
			end
			last_s10 <= last_s9;
			for (int ch = 0; ch < 3; ch++) begin
				prod = 64'(q2_s10[ch]) * 64'(RECIP);
				q3 = 9'(prod >> RECIP_SH);
				map_s11[ch] <= (q3 > 9'd255) ? 8'd255 : 8'(q3);
			end
			last_s11 <= last_s10;
		end
	end

	assign valid  = v_s11;
	assign mapped = map_s11;
	assign last   = last_s11;

endmodule

@@ sv/lut3d_trilinear_color_map.sv @@
// Throughput: one beat per cycle, writes and pixels alike, unless stalled,
// set by the eight table copies that give every corner its own read port.
// Reset clears all valid bits and sets the table size to 33; the table
// contents are undefined until written and need no clearing pass.
module lut3d_trilinear_color_map (
	input  logic            clk,
	input  logic            arst_n,
	lutm_cfg_if.sink        cfg,
	lutm_item_if.sink       item,
	lutm_result_if.source   result
);
	import lutm_pkg::*;

	// Effective size N and N*N, kept clamped so the address path needs no checks.
	logic [N_W-1:0]  n_q, n_next;
	logic [NN_W-1:0] nn_q;

	// One enable advances the whole pipeline. It is high whenever the output
	// register is empty or its beat is being taken, so every stage moves in
	// lock step with its valid bit and a stall freezes everything at once.
	logic adv;

	item_t       item_w;
	idx2mem_t    idx2mem;
	mem2blend_t  mem2blend;
	blend2norm_t blend2norm;
	logic [2:0][7:0] mapped_w;
	logic        out_valid, out_last;

	assign cfg.ready = 1'b1;

	always_comb begin
		if (32'(cfg.data) < 2)
			n_next = N_W'(2);
		else if (32'(cfg.data) > LUT_DIM)
			n_next = N_W'(LUT_DIM);
		else
			n_next = N_W'(cfg.data);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q  <= N_W'(LUT_DIM);
			nn_q <= NN_W'(LUT_DIM * LUT_DIM);
		end else if (cfg.valid && cfg.ready) begin
			n_q  <= n_next;
			nn_q <= NN_W'(n_next) * NN_W'(n_next);
		end
	end

	assign adv        = !out_valid || result.ready;
	assign item.ready = adv;

	assign item_w = '{
		op:          item.operation,
		entry_index: item.entry_index,
		entry:       {item.entry_blue, item.entry_green, item.entry_red},
		pixel:       {item.pixel_blue, item.pixel_green, item.pixel_red},
		last:        item.last_pixel
	};

	// Stages one to three: position split by 255 and corner addresses.
	lutm_index u_index (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.item_valid (item.valid),
		.item       (item_w),
		.n          (n_q),
		.nn         (nn_q),
		.to_mem     (idx2mem)
	);

	// Stage four: table write for write beats, eight corner reads for pixels.
	// A write lands at the same stage where later pixels read, so a pixel
	// right behind a write already sees the new entry.
	lutm_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.from_idx (idx2mem),
		.to_blend (mem2blend)
	);

	// Stages five to eight: exact integer weights over 255^3 and the sums.
	lutm_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.from_mem (mem2blend),
		.to_norm  (blend2norm)
	);

	// Stages nine to eleven: rounding division and the output register.
	lutm_norm u_norm (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.from_blend (blend2norm),
		.valid      (out_valid),
		.mapped     (mapped_w),
		.last       (out_last)
	);

	assign result.valid        = out_valid;
	assign result.mapped_red   = mapped_w[0];
	assign result.mapped_green = mapped_w[1];
	assign result.mapped_blue  = mapped_w[2];
	assign result.last_out     = out_last;

	// The size register always stays within the table and N*N follows it.
	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(n_q) >= 2 && 32'(n_q) <= LUT_DIM)
		else $error("table size left its legal range");
	a_size_square: assert property (@(posedge clk) disable iff (!arst_n)
		32'(nn_q) == 32'(n_q) * 32'(n_q))
		else $error("squared table size out of step with the size");

endmodule
